@@ src/camera_sector_visibility_core_macros.svh @@
// ----------------------------------------------------------------------------
// Camera sector visibility assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CAMERA_SECTOR_VISIBILITY_CORE_MACROS_SVH
`define CAMERA_SECTOR_VISIBILITY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera sector visibility check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera sector visibility check failed");

`endif

@@ src/csv_pkg.sv @@
// ----------------------------------------------------------------------------
// Camera sector visibility package
// Shared constants, types and tables of the sector visibility pipeline.
// ----------------------------------------------------------------------------
package csv_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_TYPES_DEF   = 4;

  localparam int CORDIC_ITERS = 18;
  localparam int PRE_FRAC     = 12;
  localparam int ZW           = 24;
  localparam int FOV_W        = 16;
  localparam int DIR_W        = 16;
  localparam int TYPE_W       = 2;
  localparam int SECT_W       = 19;
  localparam int IDX_W        = 8;
  localparam int DIST_W       = 25;
  localparam int MUL_W        = 30;
  localparam int GAIN_W       = 24;
  localparam int PROD_W       = 54;
  localparam int GAIN_SHIFT   = 28;
  localparam int BRG_W        = 17;

  localparam logic signed [ZW-1:0]     QUARTER_Z  = 24'sd2949120;
  localparam logic signed [ZW-1:0]     Z_ROUND    = 24'sd128;
  localparam logic signed [BRG_W-1:0]  HALF_TURN  = 17'sd23040;
  localparam logic signed [BRG_W-1:0]  FULL_TURN  = 17'sd46080;
  localparam logic signed [SECT_W-1:0] HALF_TURN2 = 19'sd46080;
  localparam logic signed [SECT_W-1:0] FULL_TURN2 = 19'sd92160;

  localparam logic [GAIN_W-1:0] INV_GAIN   = 24'd10188014;
  localparam logic [PROD_W-1:0] GAIN_ROUND = 54'd1 << (GAIN_SHIFT - 1);
  localparam logic [DIST_W-1:0] DIST_MAX   = 25'h1FFFFFF;
  localparam logic [63:0] SAT_X =
    ((64'd1 << 53) - (64'd1 << 27) + 64'(INV_GAIN) - 64'd1) / 64'(INV_GAIN);

  typedef logic [FOV_W-1:0] fov_t;

  typedef struct packed {
    logic                     zero;
    logic signed [SECT_W-1:0] lo;
    logic signed [SECT_W-1:0] hi;
  } csv_side_t;

  function automatic logic signed [ZW-1:0] arc_angle(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:       a = 24'sd1474560;
      1:       a = 24'sd870484;
      2:       a = 24'sd459940;
      3:       a = 24'sd233473;
      4:       a = 24'sd117189;
      5:       a = 24'sd58653;
      6:       a = 24'sd29333;
      7:       a = 24'sd14667;
      8:       a = 24'sd7334;
      9:       a = 24'sd3667;
      10:      a = 24'sd1833;
      11:      a = 24'sd917;
      12:      a = 24'sd458;
      13:      a = 24'sd229;
      14:      a = 24'sd115;
      15:      a = 24'sd57;
      16:      a = 24'sd29;
      17:      a = 24'sd14;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic fov_t fov_reset(input int i);
    fov_t f;
    unique case (i)
      0:       f = 16'd0;
      1:       f = 16'd7680;
      2:       f = 16'd11520;
      3:       f = 16'd15360;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  function automatic logic signed [SECT_W-1:0] wrap2(input logic signed [SECT_W-1:0] v);
    logic signed [SECT_W-1:0] w;
    w = v;
    for (int k = 0; k < 3; k++) begin
      if (w > HALF_TURN2) begin
        w = w - FULL_TURN2;
      end
      if (w <= -HALF_TURN2) begin
        w = w + FULL_TURN2;
      end
    end
    return w;
  endfunction

endpackage

@@ src/csv_if.sv @@
// ----------------------------------------------------------------------------
// Camera sector visibility channels
// Valid/ready channels for camera-target pairs, results and register writes.
// ----------------------------------------------------------------------------
interface csv_item_if #(
  parameter int COORD_WIDTH = csv_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] camera_x;
  logic signed [COORD_WIDTH-1:0] camera_y;
  logic signed [csv_pkg::DIR_W-1:0] camera_dir;
  logic [csv_pkg::TYPE_W-1:0]    camera_type;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;

  modport source (output valid, camera_x, camera_y, camera_dir, camera_type, target_x,
                  target_y, input ready);
  modport sink (input valid, camera_x, camera_y, camera_dir, camera_type, target_x,
                target_y, output ready);
endinterface

interface csv_result_if;
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic [csv_pkg::DIST_W-1:0]   distance;

  modport source (output valid, visible, distance, input ready);
  modport sink (input valid, visible, distance, output ready);
endinterface

interface csv_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [csv_pkg::IDX_W-1:0]  index;
  logic [csv_pkg::FOV_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/camera_sector_visibility_core.sv @@
// ----------------------------------------------------------------------------
// Camera sector visibility core
// Tests whether a target lies strictly inside a camera's angular sector and
// reports the camera-to-target distance.
// ----------------------------------------------------------------------------
// The core takes one camera-target transaction per clock while the result
// side is taking results, and returns one result transaction for each, in
// order: a visible flag and the Euclidean distance in unsigned Q17.8.
// Bearing and magnitude come from a chain of eighteen CORDIC vectoring
// cells, between the entry stage and the three-stage back end. Every stage
// holds its own valid bit, so a stalled result only stops the stages behind
// it once they have filled.
// Field-of-view widths are written through the configuration channel, one
// register per camera type, and are picked up by transactions accepted after
// the write; a type with no register sees a zero width and is never visible.
module camera_sector_visibility_core #(
  parameter int COORD_WIDTH = csv_pkg::COORD_WIDTH_DEF,
  parameter int NUM_TYPES   = csv_pkg::NUM_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  csv_item_if.sink          item,
  csv_result_if.source      result,
  csv_cfg_if.sink           cfg
);

  localparam int XW    = COORD_WIDTH + 15;
  localparam int TW    = $clog2(NUM_TYPES);
  localparam int ITERS = csv_pkg::CORDIC_ITERS;

  csv_pkg::fov_t fov [NUM_TYPES];
  csv_pkg::fov_t fov_sel;
  logic [csv_pkg::IDX_W-1:0] type_ext;

  logic                          cv [ITERS+1];
  logic                          cr [ITERS+1];
  logic signed [XW-1:0]          cx [ITERS+1];
  logic signed [XW-1:0]          cy [ITERS+1];
  logic signed [csv_pkg::ZW-1:0] cz [ITERS+1];
  csv_pkg::csv_side_t            cs [ITERS+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        fov[i] <= csv_pkg::fov_reset(i);
      end
    end else if (cfg.valid && (cfg.index < csv_pkg::IDX_W'(NUM_TYPES))) begin
      fov[cfg.index[TW-1:0]] <= cfg.data;
    end
  end

  always_comb begin
    type_ext = csv_pkg::IDX_W'(item.camera_type);
    if (type_ext < csv_pkg::IDX_W'(NUM_TYPES)) begin
      fov_sel = fov[type_ext[TW-1:0]];
    end else begin
      fov_sel = '0;
    end
  end

  csv_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (item.valid),
    .up_ready   (item.ready),
    .camera_x   (item.camera_x),
    .camera_y   (item.camera_y),
    .camera_dir (item.camera_dir),
    .target_x   (item.target_x),
    .target_y   (item.target_y),
    .fov        (fov_sel),
    .dn_valid   (cv[0]),
    .dn_ready   (cr[0]),
    .x_out      (cx[0]),
    .y_out      (cy[0]),
    .z_out      (cz[0]),
    .side_out   (cs[0])
  );

  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    csv_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .STAGE       (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cv[g]),
      .up_ready (cr[g]),
      .x_in     (cx[g]),
      .y_in     (cy[g]),
      .z_in     (cz[g]),
      .side_in  (cs[g]),
      .dn_valid (cv[g+1]),
      .dn_ready (cr[g+1]),
      .x_out    (cx[g+1]),
      .y_out    (cy[g+1]),
      .z_out    (cz[g+1]),
      .side_out (cs[g+1])
    );
  end

  csv_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cv[ITERS]),
    .up_ready (cr[ITERS]),
    .x_in     (cx[ITERS]),
    .z_in     (cz[ITERS]),
    .side_in  (cs[ITERS]),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .visible  (result.visible),
    .distance (result.distance)
  );

  logic unused_y;
  assign unused_y = ^cy[ITERS];

endmodule

@@ src/csv_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One rotation step of the vectoring chain, registered, with its sector data.
// ----------------------------------------------------------------------------
module csv_cell #(
  parameter int COORD_WIDTH = csv_pkg::COORD_WIDTH_DEF,
  parameter int STAGE       = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_WIDTH+14:0]    x_in,
  input  logic signed [COORD_WIDTH+14:0]    y_in,
  input  logic signed [csv_pkg::ZW-1:0]     z_in,
  input  csv_pkg::csv_side_t                side_in,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [COORD_WIDTH+14:0]    x_out,
  output logic signed [COORD_WIDTH+14:0]    y_out,
  output logic signed [csv_pkg::ZW-1:0]     z_out,
  output csv_pkg::csv_side_t                side_out
);

  localparam int XW = COORD_WIDTH + 15;
  localparam logic signed [csv_pkg::ZW-1:0] ARC = csv_pkg::arc_angle(STAGE);

  logic                         valid;
  logic signed [XW-1:0]         x;
  logic signed [XW-1:0]         y;
  logic signed [csv_pkg::ZW-1:0] z;
  csv_pkg::csv_side_t           side;
  logic signed [XW-1:0]         xs;
  logic signed [XW-1:0]         ys;
  logic signed [XW-1:0]         x_next;
  logic signed [XW-1:0]         y_next;
  logic signed [csv_pkg::ZW-1:0] z_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ARC;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      side <= side_in;
    end
  end

  assign dn_valid = valid;
  assign x_out    = x;
  assign y_out    = y;
  assign z_out    = z;
  assign side_out = side;

endmodule

@@ src/csv_front.sv @@
// ----------------------------------------------------------------------------
// Sector visibility entry stage
// Forms the offset vector, folds it into the right half plane and raises the
// raw sector bounds from the facing direction and field of view.
// ----------------------------------------------------------------------------
module csv_front #(
  parameter int COORD_WIDTH = csv_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_WIDTH-1:0]     camera_x,
  input  logic signed [COORD_WIDTH-1:0]     camera_y,
  input  logic signed [csv_pkg::DIR_W-1:0]  camera_dir,
  input  logic signed [COORD_WIDTH-1:0]     target_x,
  input  logic signed [COORD_WIDTH-1:0]     target_y,
  input  csv_pkg::fov_t                     fov,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [COORD_WIDTH+14:0]    x_out,
  output logic signed [COORD_WIDTH+14:0]    y_out,
  output logic signed [csv_pkg::ZW-1:0]     z_out,
  output csv_pkg::csv_side_t                side_out
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int XW = COORD_WIDTH + 15;

  logic                          valid;
  logic signed [XW-1:0]          x;
  logic signed [XW-1:0]          y;
  logic signed [csv_pkg::ZW-1:0] z;
  csv_pkg::csv_side_t            side;
  logic signed [DW-1:0]          dx;
  logic signed [DW-1:0]          dy;
  logic signed [DW-1:0]          x0;
  logic signed [DW-1:0]          y0;
  logic signed [csv_pkg::ZW-1:0] z0;
  logic signed [csv_pkg::SECT_W-1:0] dir2;
  logic signed [csv_pkg::SECT_W-1:0] fov_s;
  csv_pkg::csv_side_t            side_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    dx = DW'(target_x) - DW'(camera_x);
    dy = DW'(target_y) - DW'(camera_y);
    if (dx[DW-1]) begin
      if (!dy[DW-1]) begin
        x0 = dy;
        y0 = -dx;
        z0 = csv_pkg::QUARTER_Z;
      end else begin
        x0 = -dy;
        y0 = dx;
        z0 = -csv_pkg::QUARTER_Z;
      end
    end else begin
      x0 = dx;
      y0 = dy;
      z0 = '0;
    end
    dir2  = csv_pkg::SECT_W'(camera_dir) <<< 1;
    fov_s = $signed(csv_pkg::SECT_W'(fov));
    side_next.zero = (dx == '0) && (dy == '0);
    side_next.lo   = dir2 - fov_s;
    side_next.hi   = dir2 + fov_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x    <= XW'(x0) <<< csv_pkg::PRE_FRAC;
      y    <= XW'(y0) <<< csv_pkg::PRE_FRAC;
      z    <= z0;
      side <= side_next;
    end
  end

  assign dn_valid = valid;
  assign x_out    = x;
  assign y_out    = y;
  assign z_out    = z;
  assign side_out = side;

endmodule

@@ src/csv_back.sv @@
// ----------------------------------------------------------------------------
// Sector visibility back end
// Turns the vectoring result into a bearing and a distance, wraps the sector
// bounds and runs the strict sector test over three registered stages.
// ----------------------------------------------------------------------------
module csv_back #(
  parameter int COORD_WIDTH = csv_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_WIDTH+14:0]    x_in,
  input  logic signed [csv_pkg::ZW-1:0]     z_in,
  input  csv_pkg::csv_side_t                side_in,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic                              visible,
  output logic [csv_pkg::DIST_W-1:0]        distance
);

  localparam int XW = COORD_WIDTH + 15;

  logic v1;
  logic v2;
  logic v3;
  logic r1;
  logic r2;
  logic r3;

  logic signed [csv_pkg::SECT_W-1:0] b2_1;
  logic signed [csv_pkg::SECT_W-1:0] lo1;
  logic signed [csv_pkg::SECT_W-1:0] hi1;
  logic                              sat1;
  logic [csv_pkg::MUL_W-1:0]         xm1;

  logic [csv_pkg::PROD_W-1:0]        prod2;
  logic                              vis2;
  logic                              sat2;

  logic                              vis3;
  logic [csv_pkg::DIST_W-1:0]        dist3;

  logic signed [csv_pkg::ZW-1:0]     zr;
  logic signed [csv_pkg::BRG_W-1:0]  brg;
  logic signed [csv_pkg::BRG_W-1:0]  brg_w;
  logic signed [csv_pkg::SECT_W-1:0] b2_next;
  logic [63:0]                       x_ext;
  logic                              sat_next;
  logic [csv_pkg::MUL_W-1:0]         xm_next;
  logic                              vis_next;
  logic [csv_pkg::PROD_W-1:0]        sum3;
  logic [csv_pkg::DIST_W-1:0]        dist_next;

  assign r3       = !v3 || dn_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_ready = r1;

  always_comb begin
    zr  = z_in + csv_pkg::Z_ROUND;
    brg = csv_pkg::BRG_W'($signed(zr[csv_pkg::ZW-1:8]));
    if (brg > csv_pkg::HALF_TURN) begin
      brg_w = brg - csv_pkg::FULL_TURN;
    end else if (brg <= -csv_pkg::HALF_TURN) begin
      brg_w = brg + csv_pkg::FULL_TURN;
    end else begin
      brg_w = brg;
    end
    if (side_in.zero) begin
      b2_next = '0;
    end else begin
      b2_next = csv_pkg::SECT_W'(brg_w) <<< 1;
    end
    x_ext = 64'($unsigned(x_in));
    if (x_in[XW-1]) begin
      sat_next = 1'b0;
      xm_next  = '0;
    end else begin
      sat_next = x_ext >= csv_pkg::SAT_X;
      xm_next  = x_ext[csv_pkg::MUL_W-1:0];
    end
  end

  always_comb begin
    if (lo1 <= hi1) begin
      vis_next = (b2_1 > lo1) && (b2_1 < hi1);
    end else begin
      vis_next = (b2_1 > lo1) || (b2_1 < hi1);
    end
  end

  always_comb begin
    sum3 = prod2 + csv_pkg::GAIN_ROUND;
    if (sat2) begin
      dist_next = csv_pkg::DIST_MAX;
    end else begin
      dist_next = sum3[csv_pkg::GAIN_SHIFT +: csv_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= up_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      b2_1 <= b2_next;
      lo1  <= csv_pkg::wrap2(side_in.lo);
      hi1  <= csv_pkg::wrap2(side_in.hi);
      sat1 <= sat_next;
      xm1  <= xm_next;
    end
    if (r2 && v1) begin
      prod2 <= csv_pkg::PROD_W'(xm1) * csv_pkg::PROD_W'(csv_pkg::INV_GAIN);
      vis2  <= vis_next;
      sat2  <= sat1;
    end
    if (r3 && v2) begin
      vis3  <= vis2;
      dist3 <= dist_next;
    end
  end

  assign dn_valid = v3;
  assign visible  = vis3;
  assign distance = dist3;

endmodule

@@ src/csv_checker.sv @@
// ----------------------------------------------------------------------------
// Camera sector visibility checker
// Port-level checks on the visibility core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "camera_sector_visibility_core_macros.svh"

module csv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        visible,
  input logic [csv_pkg::DIST_W-1:0]  distance,
  input logic                        cfg_ready
);

  // A result is never offered in the first cycle after reset.
  `CSV_ASSERT_SAME(a_no_result_after_reset, clk, rst, $past(rst), !result_valid)

  // With the result side taking transactions, the pipeline never holds off input.
  `CSV_ASSERT_SAME(a_ready_when_drained, clk, rst, result_ready, item_ready)

  // Register writes are never held off.
  `CSV_ASSERT_SAME(a_cfg_always_ready, clk, rst, 1'b1, cfg_ready)

  `CSV_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid)

  `CSV_ASSERT_NEXT(a_result_stable, clk, rst, result_valid && !result_ready,
                   $stable(visible) && $stable(distance))

endmodule

bind camera_sector_visibility_core csv_checker u_csv_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .visible      (result.visible),
  .distance     (result.distance),
  .cfg_ready    (cfg.ready)
);

@@ sim/camera_sector_visibility_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera sector visibility core testbench
// Drives camera-target pairs and field-of-view writes into the core and
// checks every result transaction against a predicted visible flag and
// distance, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module camera_sector_visibility_core_tb;

  localparam int CW               = csv_pkg::COORD_WIDTH_DEF;
  localparam int NUM_CAMERA_TYPES = 4;
  localparam int SWEEP_STEPS      = 18;
  localparam int PHASE_ITEMS      = 306;
  localparam int DRAIN_CYCLES     = 40;

  localparam longint QUARTER_ANGLE = 2949120;
  localparam longint HALF_CIRCLE   = 23040;
  localparam longint HALF_CIRCLE2  = 46080;
  localparam longint FULL_CIRCLE2  = 92160;
  localparam longint GAIN_RECIP    = 10188014;
  localparam longint DIST_LIMIT    = 33554431;

  typedef enum logic [csv_pkg::IDX_W-1:0] {
    FOV_TYPE0     = 8'd0,
    FOV_TYPE1     = 8'd1,
    FOV_TYPE2     = 8'd2,
    FOV_TYPE3     = 8'd3,
    FOV_UNMAPPED  = 8'd4,
    FOV_INDEX_TOP = 8'd255
  } fov_index_e;

  typedef enum int {FLOW_FREE, FLOW_CHOPPY, FLOW_BLOCKED} flow_e;

  typedef struct packed {
    logic signed [CW-1:0]                 camera_x;
    logic signed [CW-1:0]                 camera_y;
    logic signed [csv_pkg::DIR_W-1:0]     camera_dir;
    logic [csv_pkg::TYPE_W-1:0]           camera_type;
    logic signed [CW-1:0]                 target_x;
    logic signed [CW-1:0]                 target_y;
  } camera_pair_t;

  typedef struct {
    logic                        visible;
    logic [csv_pkg::DIST_W-1:0]  distance;
  } sighting_t;

  class visibility_scoreboard;
    logic [csv_pkg::FOV_W-1:0] fov_width [NUM_CAMERA_TYPES];
    longint                    arc_step [SWEEP_STEPS];
    sighting_t                 pending_sightings [$];
    int                        error_count;

    function new();
      fov_width = '{16'd0, 16'd7680, 16'd11520, 16'd15360};
      arc_step = '{1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
                   7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14};
      error_count = 0;
    endfunction

    function void write_fov(logic [csv_pkg::IDX_W-1:0] index,
                            logic [csv_pkg::FOV_W-1:0] width);
      if (index < NUM_CAMERA_TYPES) begin
        fov_width[index[1:0]] = width;
      end
    endfunction

    function longint wrap_sector(longint v);
      longint w;
      w = v;
      for (int k = 0; k < 3; k++) begin
        if (w > HALF_CIRCLE2) begin
          w = w - FULL_CIRCLE2;
        end
        if (w <= -HALF_CIRCLE2) begin
          w = w + FULL_CIRCLE2;
        end
      end
      return w;
    endfunction

    function sighting_t sight_target(camera_pair_t p);
      longint    dx, dy, x, y, z, xs, ys;
      longint    bearing, fov, dir, lo, hi, b2, range_q;
      sighting_t s;
      dx = longint'($signed(p.target_x)) - longint'($signed(p.camera_x));
      dy = longint'($signed(p.target_y)) - longint'($signed(p.camera_y));
      dir = longint'($signed(p.camera_dir));
      bearing = 0;
      range_q = 0;
      if (dx != 0 || dy != 0) begin
        if (dx < 0) begin
          if (dy >= 0) begin
            x = dy;
            y = -dx;
            z = QUARTER_ANGLE;
          end else begin
            x = -dy;
            y = dx;
            z = -QUARTER_ANGLE;
          end
        end else begin
          x = dx;
          y = dy;
          z = 0;
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < SWEEP_STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arc_step[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - arc_step[i];
          end
        end
        bearing = (z + 128) >>> 8;
        if (bearing > HALF_CIRCLE) begin
          bearing = bearing - 2 * HALF_CIRCLE;
        end
        if (bearing <= -HALF_CIRCLE) begin
          bearing = bearing + 2 * HALF_CIRCLE;
        end
        if (x < 0) begin
          x = 0;
        end
        range_q = (x * GAIN_RECIP + (longint'(1) <<< 27)) >>> 28;
        if (range_q > DIST_LIMIT) begin
          range_q = DIST_LIMIT;
        end
      end
      fov = (p.camera_type < NUM_CAMERA_TYPES) ? longint'(fov_width[p.camera_type]) : 0;
      lo = wrap_sector(2 * dir - fov);
      hi = wrap_sector(2 * dir + fov);
      b2 = 2 * bearing;
      if (lo <= hi) begin
        s.visible = (b2 > lo) && (b2 < hi);
      end else begin
        s.visible = (b2 > lo) || (b2 < hi);
      end
      s.distance = range_q[csv_pkg::DIST_W-1:0];
      return s;
    endfunction

    function void note_item(camera_pair_t p);
      pending_sightings.push_back(sight_target(p));
    endfunction

    function int pending();
      return pending_sightings.size();
    endfunction

    task report(string line);
      $display("%0t ns: %s", $time, line);
      error_count++;
    endtask

    task check_result(logic visible, logic [csv_pkg::DIST_W-1:0] distance);
      sighting_t want;
      if (pending_sightings.size() == 0) begin
        report($sformatf("unexpected result transaction visible=%0d distance=%0d",
                         visible, distance));
      end else begin
        want = pending_sightings.pop_front();
        if (visible !== want.visible) begin
          report($sformatf("visible mismatch: got %0d, predicted %0d",
                           visible, want.visible));
        end
        if (distance !== want.distance) begin
          report($sformatf("distance mismatch: got %0d, predicted %0d",
                           distance, want.distance));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   stall_left;
  int   mode_left;
  flow_e stall_mode;

  visibility_scoreboard sb = new();

  csv_item_if #(.COORD_WIDTH(CW)) pair_bus ();
  csv_result_if                   sighting_bus ();
  csv_cfg_if                      fov_bus ();

  camera_sector_visibility_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (pair_bus),
    .result (sighting_bus),
    .cfg    (fov_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (fov_bus.valid && fov_bus.ready) begin
        sb.write_fov(fov_bus.index, fov_bus.data);
      end
      if (pair_bus.valid && pair_bus.ready) begin
        sb.note_item('{camera_x: pair_bus.camera_x, camera_y: pair_bus.camera_y,
                       camera_dir: pair_bus.camera_dir, camera_type: pair_bus.camera_type,
                       target_x: pair_bus.target_x, target_y: pair_bus.target_y});
      end
      if (sighting_bus.valid && sighting_bus.ready) begin
        sb.check_result(sighting_bus.visible, sighting_bus.distance);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sighting_bus.ready = 1'b0;
      stall_left = 0;
      mode_left = 0;
      stall_mode = FLOW_FREE;
    end else begin
      if (mode_left == 0) begin
        stall_mode = flow_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        sighting_bus.ready = 1'b0;
        stall_left--;
      end else begin
        sighting_bus.ready = 1'b1;
        if (stall_mode == FLOW_CHOPPY && $urandom_range(0, 2) == 0) begin
          stall_left = $urandom_range(1, 3);
        end else if (stall_mode == FLOW_BLOCKED && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 30);
        end
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v < -32768) begin
      return -32768;
    end
    if (v > 32767) begin
      return 32767;
    end
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic camera_pair_t random_pair();
    camera_pair_t p;
    int           cx, cy, tx, ty, dir, sel, kind, half, offset, d;
    real          ang, radius;
    cx = any_coord();
    cy = any_coord();
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      dir = int'($urandom_range(0, 46080)) - 23040;
    end else if (sel == 8) begin
      dir = any_coord();
    end else begin
      case ($urandom_range(0, 4))
        0: dir = -23040;
        1: dir = 23040;
        2: dir = 0;
        3: dir = 32767;
        default: dir = -32768;
      endcase
    end
    p.camera_type = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 19);
    d = int'($urandom_range(1, 2000)) * ($urandom_range(0, 1) ? 1 : -1);
    if (kind == 0) begin
      tx = cx;
      ty = cy;
    end else if (kind <= 2) begin
      tx = (kind == 1) ? clamp_coord(cx + d) : cx;
      ty = (kind == 2) ? clamp_coord(cy + d) : cy;
    end else if (kind <= 8) begin
      tx = any_coord();
      ty = any_coord();
    end else if (kind <= 13) begin
      tx = clamp_coord(cx + int'($urandom_range(0, 128)) - 64);
      ty = clamp_coord(cy + int'($urandom_range(0, 128)) - 64);
    end else begin
      half = int'(sb.fov_width[p.camera_type]) / 2 + 640;
      offset = int'($urandom_range(0, 2 * half)) - half;
      ang = real'(dir + offset) / 128.0 * 3.14159265358979 / 180.0;
      radius = real'($urandom_range(1, 4000));
      tx = clamp_coord(cx + int'(radius * $cos(ang)));
      ty = clamp_coord(cy + int'(radius * $sin(ang)));
    end
    p.camera_x = CW'(cx);
    p.camera_y = CW'(cy);
    p.camera_dir = 16'(dir);
    p.target_x = CW'(tx);
    p.target_y = CW'(ty);
    return p;
  endfunction

  task automatic send_pair(camera_pair_t p);
    pair_bus.valid = 1'b1;
    pair_bus.camera_x = p.camera_x;
    pair_bus.camera_y = p.camera_y;
    pair_bus.camera_dir = p.camera_dir;
    pair_bus.camera_type = p.camera_type;
    pair_bus.target_x = p.target_x;
    pair_bus.target_y = p.target_y;
    @(posedge clk);
    while (!pair_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic aim(int cx, int cy, int dir, int type_sel, int tx, int ty);
    camera_pair_t p;
    p.camera_x = CW'(cx);
    p.camera_y = CW'(cy);
    p.camera_dir = 16'(dir);
    p.camera_type = 2'(type_sel);
    p.target_x = CW'(tx);
    p.target_y = CW'(ty);
    send_pair(p);
  endtask

  task automatic pause_sender(int cycles);
    pair_bus.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    pair_bus.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_fov_reg(fov_index_e index, logic [csv_pkg::FOV_W-1:0] width);
    fov_bus.valid = 1'b1;
    fov_bus.index = index;
    fov_bus.data = width;
    @(posedge clk);
    while (!fov_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    fov_bus.valid = 1'b0;
  endtask

  task automatic set_fov_widths(int w0, int w1, int w2, int w3);
    drain();
    write_fov_reg(FOV_TYPE0, 16'(w0));
    write_fov_reg(FOV_TYPE1, 16'(w1));
    write_fov_reg(FOV_TYPE2, 16'(w2));
    write_fov_reg(FOV_TYPE3, 16'(w3));
  endtask

  task automatic run_random(int count);
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 8));
        end
      end
      if ($urandom_range(0, 249) == 0) begin
        drain();
      end
      send_pair(random_pair());
      burst_left--;
    end
  endtask

  task automatic probe_straight_ahead();
    for (int k = 0; k < NUM_CAMERA_TYPES; k++) begin
      aim(0, 0, 0, k, 500, 0);
      aim(0, 0, 23040, k, -500, 0);
      aim(10, 10, -5760, k, 20, 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    pair_bus.valid = 1'b0;
    pair_bus.camera_x = '0;
    pair_bus.camera_y = '0;
    pair_bus.camera_dir = '0;
    pair_bus.camera_type = '0;
    pair_bus.target_x = '0;
    pair_bus.target_y = '0;
    fov_bus.valid = 1'b0;
    fov_bus.index = '0;
    fov_bus.data = '0;
    sighting_bus.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    aim(0, 0, 0, 1, 0, 0);
    aim(-32768, -32768, 0, 3, 32767, 32767);
    aim(32767, 32767, -11520, 3, -32768, -32768);
    aim(32767, -32768, 23040, 2, -32768, 32767);
    aim(100, 0, 23040, 2, 0, 0);
    aim(100, 0, -23040, 2, 0, 0);
    aim(0, 0, 11520, 1, 0, 5);
    aim(0, 0, -11520, 1, 0, -5);
    aim(0, 0, 0, 0, 500, 0);
    aim(0, 0, 32767, 3, -100, 1);
    aim(0, 0, -32768, 3, -100, -1);
    aim(0, 0, 0, 2, 100, 100);
    aim(0, 0, 0, 2, 100, -100);
    aim(0, 0, 22000, 3, -1000, -10);
    aim(-1, 0, 0, 1, -2, 0);
    aim(0, -1, 0, 1, 0, 0);
    aim(32767, 0, 0, 1, -32768, 0);
    aim(0, 32767, 0, 1, 0, -32768);
    aim(5, 5, 5760, 2, 4, 4);
    run_random(PHASE_ITEMS);

    set_fov_widths(0, 46080, 23040, 1);
    write_fov_reg(FOV_UNMAPPED, 16'd128);
    write_fov_reg(FOV_INDEX_TOP, 16'hFFFF);
    probe_straight_ahead();
    run_random(PHASE_ITEMS);

    set_fov_widths($urandom_range(0, 46080), $urandom_range(0, 46080),
                   $urandom_range(0, 46080), $urandom_range(0, 46080));
    run_random(PHASE_ITEMS);

    set_fov_widths(46080, 65535, 0, 128);
    probe_straight_ahead();
    run_random(PHASE_ITEMS);

    set_fov_widths($urandom_range(0, 46080), 46079, $urandom_range(0, 46080), 1);
    run_random(PHASE_ITEMS);

    drain();
    pause_sender(DRAIN_CYCLES);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ camera_sector_visibility_core.f @@
+incdir+src
src/csv_pkg.sv
src/csv_if.sv
src/csv_cell.sv
src/csv_front.sv
src/csv_back.sv
src/camera_sector_visibility_core.sv
src/csv_checker.sv
sim/camera_sector_visibility_core_tb.sv
